>>> src/ile_pkg.sv
// package: command codes, beat structs and controller states for the list engine
package ile_pkg;

    typedef enum logic [2:0] {
        CMD_APPEND = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_GET    = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [8:0]  position;
        logic [31:0] data_in;
    } in_beat_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] data_out;
        logic [8:0]  count;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DECIDE,
        ST_WALK_RD,
        ST_WALK_WAIT,
        ST_WALK_STEP,
        ST_NODE_RD,
        ST_NODE_WAIT,
        ST_UPDATE,
        ST_CLEAR,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic walk_init;
        logic walk_rd;
        logic walk_step;
        logic node_rd;
        logic update;
        logic clear_start;
        logic clear_step;
        logic finish;
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic need_walk;
        logic is_clear;
        logic walk_done;
        logic clear_done;
    } stat_t;

endpackage

>>> src/ile_ctrl.sv
// controller state machine: sequences decode, link walk, node update and clear
module ile_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  ile_pkg::stat_t stat,
    output logic           busy,
    output ile_pkg::ctrl_t ctrl
);

    ile_pkg::state_t state_reg;
    ile_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ile_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ile_pkg::ST_INIT:
            begin
                if (stat.clear_done)
                begin
                    state_next = ile_pkg::ST_IDLE;
                end
            end
            ile_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ile_pkg::ST_DECIDE;
                end
            end
            ile_pkg::ST_DECIDE:
            begin
                priority if (stat.is_clear)
                begin
                    state_next = ile_pkg::ST_CLEAR;
                end
                else if (stat.need_walk)
                begin
                    state_next = ile_pkg::ST_WALK_RD;
                end
                else
                begin
                    state_next = ile_pkg::ST_UPDATE;
                end
            end
            ile_pkg::ST_WALK_RD:
            begin
                if (stat.walk_done)
                begin
                    state_next = ile_pkg::ST_NODE_RD;
                end
                else
                begin
                    state_next = ile_pkg::ST_WALK_WAIT;
                end
            end
            ile_pkg::ST_WALK_WAIT: state_next = ile_pkg::ST_WALK_STEP;
            ile_pkg::ST_WALK_STEP: state_next = ile_pkg::ST_WALK_RD;
            ile_pkg::ST_NODE_RD:   state_next = ile_pkg::ST_NODE_WAIT;
            ile_pkg::ST_NODE_WAIT: state_next = ile_pkg::ST_UPDATE;
            ile_pkg::ST_UPDATE:    state_next = ile_pkg::ST_DONE;
            ile_pkg::ST_CLEAR:
            begin
                if (stat.clear_done)
                begin
                    state_next = ile_pkg::ST_DONE;
                end
            end
            ile_pkg::ST_DONE:      state_next = ile_pkg::ST_IDLE;
            default:               state_next = ile_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        busy = (state_reg != ile_pkg::ST_IDLE);
        unique case (state_reg)
            // fill the free stack with every slot number after reset
            ile_pkg::ST_INIT:      ctrl.clear_step = 1'b1;
            ile_pkg::ST_IDLE:      ctrl.latch = start;
            ile_pkg::ST_DECIDE:
            begin
                ctrl.walk_init   = 1'b1;
                ctrl.clear_start = stat.is_clear;
            end
            ile_pkg::ST_WALK_RD:   ctrl.walk_rd = !stat.walk_done;
            ile_pkg::ST_WALK_WAIT: ctrl.walk_rd = 1'b0;
            ile_pkg::ST_WALK_STEP: ctrl.walk_step = 1'b1;
            ile_pkg::ST_NODE_RD:   ctrl.node_rd = 1'b1;
            ile_pkg::ST_NODE_WAIT: ctrl.node_rd = 1'b0;
            ile_pkg::ST_UPDATE:    ctrl.update = 1'b1;
            ile_pkg::ST_CLEAR:     ctrl.clear_step = 1'b1;
            ile_pkg::ST_DONE:      ctrl.finish = 1'b1;
            default:               ctrl = '0;
        endcase
    end

endmodule

>>> src/ile_datapath.sv
// datapath: node memories, free stack, list pointers and result register
module ile_datapath #(
    parameter int CAPACITY   = 256,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ile_pkg::in_beat_t   request,
    input  ile_pkg::ctrl_t      ctrl,
    output ile_pkg::stat_t      stat,
    output logic                done,
    output ile_pkg::out_beat_t  result
);

    localparam int AW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [DATA_WIDTH-1:0] node_data [CAPACITY];
    logic [AW-1:0]         next_link [CAPACITY];
    logic [AW-1:0]         prev_link [CAPACITY];
    logic [AW-1:0]         free_slots [CAPACITY];

    ile_pkg::cmd_t         cmd_reg;
    logic [8:0]            pos_reg;
    logic [DATA_WIDTH-1:0] din_reg;
    logic [CW-1:0]         free_top_reg;
    logic [AW-1:0]         head_reg;
    logic [AW-1:0]         tail_reg;
    logic [CW-1:0]         count_reg;
    logic [8:0]            step_reg;
    logic [AW-1:0]         cur_reg;
    logic [AW-1:0]         rd_next_reg;
    logic [AW-1:0]         rd_prev_reg;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [AW-1:0]         alloc_reg;
    logic [CW-1:0]         clr_idx_reg;
    logic                  done_reg;
    ile_pkg::out_beat_t    result_reg;

    logic [9:0]  cnt_ext;
    logic [9:0]  pos_ext;
    logic        full;
    logic        ins_ok;
    logic        pos_ok;
    logic        do_ins;
    logic        is_app;
    logic        ok_now;
    logic        ret_data;
    logic [CW-1:0] ft_m1;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] alloc_slot;

    assign cnt_ext = 10'(count_reg);
    assign pos_ext = {1'b0, pos_reg};
    assign full    = (free_top_reg == '0) || (count_reg >= CW'(CAPACITY));
    assign ft_m1   = free_top_reg - CW'(1);
    assign alloc_slot = alloc_reg;
    // append, or insert at the tail position
    assign is_app  = (cmd_reg == ile_pkg::CMD_APPEND) ||
                     (cmd_reg == ile_pkg::CMD_INSERT && pos_ext == cnt_ext);
    assign do_ins  = (cmd_reg == ile_pkg::CMD_INSERT) && pos_ext < cnt_ext &&
                     pos_reg != 9'd0;
    assign ins_ok  = !full;
    assign pos_ok  = pos_ext < cnt_ext;

    always_comb
    begin
        ok_now = 1'b0;
        unique case (cmd_reg)
            ile_pkg::CMD_APPEND: ok_now = ins_ok;
            ile_pkg::CMD_INSERT: ok_now = (pos_ext <= cnt_ext) && ins_ok;
            ile_pkg::CMD_REMOVE: ok_now = pos_ok;
            ile_pkg::CMD_GET:    ok_now = pos_ok;
            ile_pkg::CMD_CLEAR:  ok_now = 1'b1;
            default:             ok_now = 1'b0;
        endcase
    end

    // remove and get return the word read at the walked slot
    assign ret_data = ok_now && ((cmd_reg == ile_pkg::CMD_REMOVE) ||
                      (cmd_reg == ile_pkg::CMD_GET));

    assign stat.is_clear   = (cmd_reg == ile_pkg::CMD_CLEAR);
    assign stat.need_walk  = ok_now && ((cmd_reg == ile_pkg::CMD_REMOVE) ||
                             (cmd_reg == ile_pkg::CMD_GET) || do_ins);
    assign stat.walk_done  = (step_reg == pos_reg);
    assign stat.clear_done = (clr_idx_reg == CW'(CAPACITY - 1));
    assign done   = done_reg;
    assign result = result_reg;

    assign rd_addr = cur_reg;

    // link and data reads, registered
    always_ff @(posedge clk)
    begin
        rd_next_reg <= next_link[rd_addr];
        rd_prev_reg <= prev_link[rd_addr];
        rd_data_reg <= node_data[rd_addr];
        alloc_reg   <= free_slots[ft_m1[AW-1:0]];
    end

    // node and link writes happen in the update state; the free stack is also filled during init and clear
    always_ff @(posedge clk)
    begin
        if (ctrl.clear_step)
        begin
            free_slots[clr_idx_reg[AW-1:0]] <= clr_idx_reg[AW-1:0];
        end
        else if (ctrl.update && ok_now)
        begin
            unique case (cmd_reg)
                ile_pkg::CMD_APPEND, ile_pkg::CMD_INSERT:
                begin
                    node_data[alloc_slot] <= din_reg;
                    if (is_app)
                    begin
                        next_link[alloc_slot] <= '0;
                        prev_link[alloc_slot] <= (count_reg == '0) ? '0 : tail_reg;
                        if (count_reg != '0)
                        begin
                            next_link[tail_reg] <= alloc_slot;
                        end
                    end
                    else if (pos_reg == 9'd0)
                    begin
                        next_link[alloc_slot] <= head_reg;
                        prev_link[alloc_slot] <= '0;
                        prev_link[head_reg]   <= alloc_slot;
                    end
                    else
                    begin
                        next_link[alloc_slot] <= cur_reg;
                        prev_link[alloc_slot] <= rd_prev_reg;
                        next_link[rd_prev_reg] <= alloc_slot;
                        prev_link[cur_reg]    <= alloc_slot;
                    end
                end
                ile_pkg::CMD_REMOVE:
                begin
                    if (count_reg != CW'(1))
                    begin
                        if (pos_reg == 9'd0)
                        begin
                            prev_link[rd_next_reg] <= '0;
                        end
                        else if (pos_ext == cnt_ext - 10'd1)
                        begin
                            next_link[rd_prev_reg] <= '0;
                        end
                        else
                        begin
                            prev_link[rd_next_reg] <= rd_prev_reg;
                            next_link[rd_prev_reg] <= rd_next_reg;
                        end
                    end
                    if (free_top_reg < CW'(CAPACITY))
                    begin
                        free_slots[free_top_reg[AW-1:0]] <= cur_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.latch)
        begin
            pos_reg <= request.position;
            din_reg <= DATA_WIDTH'(request.data_in);
        end
        if (ctrl.walk_init)
        begin
            step_reg <= '0;
            cur_reg  <= head_reg;
        end
        else if (ctrl.walk_step)
        begin
            step_reg <= step_reg + 9'd1;
            cur_reg  <= rd_next_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg      <= ile_pkg::CMD_APPEND;
            free_top_reg <= CW'(CAPACITY);
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            clr_idx_reg  <= '0;
            done_reg     <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            done_reg <= ctrl.finish;
            if (ctrl.latch)
            begin
                cmd_reg <= ile_pkg::cmd_t'(request.command);
            end
            if (ctrl.clear_start)
            begin
                clr_idx_reg <= '0;
            end
            else if (ctrl.clear_step)
            begin
                clr_idx_reg <= clr_idx_reg + CW'(1);
            end
            if (ctrl.clear_start)
            begin
                free_top_reg <= CW'(CAPACITY);
                head_reg     <= '0;
                tail_reg     <= '0;
                count_reg    <= '0;
            end
            // refresh count at finish; clear has no update cycle
            if (ctrl.finish)
            begin
                result_reg.count <= 9'(count_reg);
                if (cmd_reg == ile_pkg::CMD_CLEAR)
                begin
                    result_reg.ok       <= 1'b1;
                    result_reg.data_out <= '0;
                end
            end
            if (ctrl.update)
            begin
                result_reg.ok       <= ok_now;
                result_reg.data_out <= ret_data ? 32'(rd_data_reg) : 32'd0;
                if (ok_now)
                begin
                    unique case (cmd_reg)
                        ile_pkg::CMD_APPEND, ile_pkg::CMD_INSERT:
                        begin
                            free_top_reg <= ft_m1;
                            count_reg    <= count_reg + CW'(1);
                            if (is_app)
                            begin
                                tail_reg <= alloc_slot;
                                if (count_reg == '0)
                                begin
                                    head_reg <= alloc_slot;
                                end
                            end
                            else if (pos_reg == 9'd0)
                            begin
                                head_reg <= alloc_slot;
                            end
                        end
                        ile_pkg::CMD_REMOVE:
                        begin
                            count_reg <= count_reg - CW'(1);
                            if (free_top_reg < CW'(CAPACITY))
                            begin
                                free_top_reg <= free_top_reg + CW'(1);
                            end
                            if (count_reg == CW'(1))
                            begin
                                head_reg <= '0;
                                tail_reg <= '0;
                            end
                            else if (pos_reg == 9'd0)
                            begin
                                head_reg <= rd_next_reg;
                            end
                            else if (pos_ext == cnt_ext - 10'd1)
                            begin
                                tail_reg <= rd_prev_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
        end
    end

endmodule

>>> src/indexed_list_engine.sv
// indexed_list_engine: ordered list of data words held as a doubly linked list
//
// usage: drive command, position and data_in with start high while busy is low;
// that edge takes the request beat. busy stays high until the result beat.
// the result (ok, data_out, count) is shown for one cycle with result_valid high
// and is taken at the end of that cycle; the receiver cannot stall it.
// append, position-zero insert, failed and unknown commands skip the link
// walk and go straight to the update. remove, get and middle insert walk next
// links from the head, one link at a time (registered memory read), then read
// the node at that position before the update. clear restores the free stack
// one slot a cycle and has no update step. one request is worked on at a time;
// busy is low during the result beat, so the next request can be taken at the
// edge that ends it.
// reset: the list is empty; busy stays high after reset while the free stack
// is filled with every slot number, one slot a cycle.
module indexed_list_engine #(
    parameter int CAPACITY   = 256,
    parameter int DATA_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  ile_pkg::in_beat_t  request,
    output logic               busy,
    output logic               result_valid,
    output ile_pkg::out_beat_t result
);

    ile_pkg::ctrl_t ctrl;
    ile_pkg::stat_t stat;

    ile_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    ile_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .ctrl    (ctrl),
        .stat    (stat),
        .done    (result_valid),
        .result  (result)
    );

endmodule

>>> src/ile_checker.sv
// checker on the top level ports, bound to the list engine
module ile_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               result_valid,
    input ile_pkg::out_beat_t result
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result beat longer than one cycle");

    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("busy during result beat");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.ok) |-> (result.data_out == '0))
        else $error("failed command returned data");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.count <= 9'd256))
        else $error("count out of range");

endmodule

bind indexed_list_engine ile_checker u_ile_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);
